// File: hdl/ipp_pkg.sv
`default_nettype none

package ipp_pkg;

	// Field widths
	localparam int unsigned SpeedW = 16;
	localparam int unsigned ErrW   = SpeedW + 1;
	localparam int unsigned CoefW  = 16;
	localparam int unsigned ProdW  = CoefW + ErrW;
	localparam int unsigned AccW   = ProdW + 2;
	localparam int unsigned FracW  = 8;
	localparam int unsigned StepW  = AccW - FracW;
	localparam int unsigned DutyW  = 16;
	localparam int unsigned SumW   = StepW + 1;
	localparam int unsigned CfgW   = 16;
	localparam int unsigned CfgIdxW = 3;

	typedef logic signed [ErrW-1:0]  err_t;
	typedef logic signed [StepW-1:0] step_t;
	typedef logic [DutyW-1:0]        duty_t;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_NOW  = 3'd0,
		REG_GAIN_LAST = 3'd1,
		REG_GAIN_PREV = 3'd2,
		REG_DEADBAND  = 3'd3,
		REG_STEP_MAX  = 3'd4,
		REG_STEP_MIN  = 3'd5,
		REG_DUTY_MAX  = 3'd6,
		REG_DUTY_MIN  = 3'd7
	} cfg_reg_t;

	// Register reset values
	localparam logic [CfgW-1:0] StepMaxRst = 16'h7FFF;
	localparam logic [CfgW-1:0] StepMinRst = 16'h8000;
	localparam logic [CfgW-1:0] DutyMaxRst = 16'hFFFF;
	localparam logic [CfgW-1:0] DutyMinRst = 16'h0000;

endpackage

`default_nettype wire

// File: hdl/incremental_pid_pwm_core.sv
`default_nettype none

// Channel   Signals                               Direction  Handshake
// sample    setpoint, feedback                    in         sample_valid / sample_ready
// result    duty, applied_step, held              out        result_valid / result_ready
// config    cfg_index, cfg_data                   in         cfg_we (no wait)
//
// One sample per clock is sustained while result_ready stays high. A sample accepted at
// one edge sits in the input register, is evaluated there and moves to the result
// register when the input stage advances.
// The feedback through error history, last increment and duty accumulator closes in
// the combinational evaluation, which sets the clock period (three 16x17 multiplies,
// a sum, two clamps, an add and two more clamps).
// Reset (arst_n low, asynchronous) clears the error history, the stored increment, the
// duty accumulator and the valid flags, and loads the register defaults.
// When result_ready is low the result register holds; the input register still takes
// one more sample, after which sample_ready falls until the result is taken.

module incremental_pid_pwm_core (
	input  wire                                   clk,
	input  wire                                   arst_n,

	input  wire                                   sample_valid,
	output logic                                  sample_ready,
	input  wire  signed [ipp_pkg::SpeedW-1:0]     setpoint,
	input  wire  signed [ipp_pkg::SpeedW-1:0]     feedback,

	output logic                                  result_valid,
	input  wire                                   result_ready,
	output logic        [ipp_pkg::DutyW-1:0]      duty,
	output logic signed [ipp_pkg::StepW-1:0]      applied_step,
	output logic                                  held,

	input  wire                                   cfg_we,
	input  wire         [ipp_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire         [ipp_pkg::CfgW-1:0]       cfg_data
);

	// Configuration registers.
	logic signed [ipp_pkg::CoefW-1:0] gain_now_q;
	logic signed [ipp_pkg::CoefW-1:0] gain_last_q;
	logic signed [ipp_pkg::CoefW-1:0] gain_prev_q;
	logic        [ipp_pkg::CfgW-1:0]  deadband_q;
	logic signed [ipp_pkg::CfgW-1:0]  step_max_q;
	logic signed [ipp_pkg::CfgW-1:0]  step_min_q;
	logic        [ipp_pkg::DutyW-1:0] duty_max_q;
	logic        [ipp_pkg::DutyW-1:0] duty_min_q;

	// Controller state carried from one sample to the next.
	ipp_pkg::err_t  error_last_q;
	ipp_pkg::err_t  error_prev_q;
	ipp_pkg::step_t raw_step_q;
	ipp_pkg::duty_t duty_acc_q;

	// Input register.
	logic                              valid_s1;
	logic signed [ipp_pkg::SpeedW-1:0] setpoint_s1;
	logic signed [ipp_pkg::SpeedW-1:0] feedback_s1;

	// Evaluation results.
	logic           advance;
	ipp_pkg::err_t  error_next;
	logic           held_next;
	ipp_pkg::step_t raw_next;
	ipp_pkg::step_t applied_next;
	ipp_pkg::duty_t duty_next;

	// The input stage moves forward whenever the result register is empty or is being
	// emptied in this cycle; a new sample can then enter behind it.
	assign advance      = valid_s1 && (!result_valid || result_ready);
	assign sample_ready = !valid_s1 || advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_now_q  <= '0;
			gain_last_q <= '0;
			gain_prev_q <= '0;
			deadband_q  <= '0;
			step_max_q  <= ipp_pkg::StepMaxRst;
			step_min_q  <= ipp_pkg::StepMinRst;
			duty_max_q  <= ipp_pkg::DutyMaxRst;
			duty_min_q  <= ipp_pkg::DutyMinRst;
		end else if (cfg_we) begin
			case (ipp_pkg::cfg_reg_t'(cfg_index))
				ipp_pkg::REG_GAIN_NOW:  gain_now_q  <= cfg_data;
				ipp_pkg::REG_GAIN_LAST: gain_last_q <= cfg_data;
				ipp_pkg::REG_GAIN_PREV: gain_prev_q <= cfg_data;
				ipp_pkg::REG_DEADBAND:  deadband_q  <= cfg_data;
				ipp_pkg::REG_STEP_MAX:  step_max_q  <= cfg_data;
				ipp_pkg::REG_STEP_MIN:  step_min_q  <= cfg_data;
				ipp_pkg::REG_DUTY_MAX:  duty_max_q  <= cfg_data;
				ipp_pkg::REG_DUTY_MIN:  duty_min_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: the valid flag is control, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			setpoint_s1 <= setpoint;
			feedback_s1 <= feedback;
		end
	end

	// Evaluation of the sample held in the input register.
	always_comb begin
		logic        [ipp_pkg::ErrW-1:0]  err_mag;
		logic signed [ipp_pkg::ProdW-1:0] prod_now;
		logic signed [ipp_pkg::ProdW-1:0] prod_last;
		logic signed [ipp_pkg::ProdW-1:0] prod_prev;
		logic signed [ipp_pkg::AccW-1:0]  acc;
		logic signed [ipp_pkg::AccW-1:0]  acc_biased;
		logic signed [ipp_pkg::SumW-1:0]  duty_sum;

		error_next = ipp_pkg::ErrW'(setpoint_s1) - ipp_pkg::ErrW'(feedback_s1);
		err_mag    = error_next[ipp_pkg::ErrW-1] ? -error_next : error_next;
		held_next  = err_mag < {1'b0, deadband_q};

		// Q8.8 weighted sum of the current and two earlier errors.
		prod_now  = gain_now_q  * error_next;
		prod_last = gain_last_q * error_last_q;
		prod_prev = gain_prev_q * error_prev_q;
		acc = ipp_pkg::AccW'(prod_now) + ipp_pkg::AccW'(prod_last)
		    + ipp_pkg::AccW'(prod_prev);

		// Drop the fraction, rounding toward zero: negative sums are biased up first.
		acc_biased = acc + (acc[ipp_pkg::AccW-1]
		             ? ipp_pkg::AccW'((1 << ipp_pkg::FracW) - 1) : '0);
		raw_next   = acc_biased[ipp_pkg::AccW-1:ipp_pkg::FracW];

		// Inside the deadband the stored increment is reused without clamping.
		// Otherwise the upper clamp is applied first, so an inverted pair
		// leaves the lower limit in force.
		if (held_next) begin
			applied_next = raw_step_q;
		end else begin
			applied_next = raw_next;
			if (applied_next >= ipp_pkg::StepW'(step_max_q)) begin
				applied_next = ipp_pkg::StepW'(step_max_q);
			end
			if (applied_next <= ipp_pkg::StepW'(step_min_q)) begin
				applied_next = ipp_pkg::StepW'(step_min_q);
			end
		end

		// Accumulate and clamp the duty; duty_min wins over an inverted pair.
		duty_sum = $signed({{(ipp_pkg::SumW-ipp_pkg::DutyW){1'b0}}, duty_acc_q})
		         + ipp_pkg::SumW'(applied_next);
		if (duty_sum > $signed({{(ipp_pkg::SumW-ipp_pkg::DutyW){1'b0}}, duty_max_q})) begin
			duty_sum = $signed({{(ipp_pkg::SumW-ipp_pkg::DutyW){1'b0}}, duty_max_q});
		end
		if (duty_sum < $signed({{(ipp_pkg::SumW-ipp_pkg::DutyW){1'b0}}, duty_min_q})) begin
			duty_sum = $signed({{(ipp_pkg::SumW-ipp_pkg::DutyW){1'b0}}, duty_min_q});
		end
		duty_next = duty_sum[ipp_pkg::DutyW-1:0];
	end

	// State update: happens exactly when the sample leaves the input register, so the
	// sample right behind it sees the new history in the very next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_last_q <= '0;
			error_prev_q <= '0;
			raw_step_q   <= '0;
			duty_acc_q   <= '0;
		end else if (advance) begin
			duty_acc_q <= duty_next;
			if (!held_next) begin
				error_prev_q <= error_last_q;
				error_last_q <= error_next;
				raw_step_q   <= raw_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty         <= duty_next;
			applied_step <= applied_next;
			held         <= held_next;
		end
	end

`ifndef NO_ASSERTIONS
	// The duty handed on always respects an ordered pair of duty limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (duty_min_q <= duty_max_q) |->
			(duty_next >= duty_min_q) && (duty_next <= duty_max_q))
		else $error("duty left its limits");

	// A fresh increment respects an ordered pair of step limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !held_next && (step_min_q <= step_max_q) |->
			(applied_next >= ipp_pkg::StepW'(step_min_q)) &&
			(applied_next <= ipp_pkg::StepW'(step_max_q)))
		else $error("fresh increment left its limits");

	// A sample inside the deadband leaves the error history and increment untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && held_next |=>
			$stable(raw_step_q) && $stable(error_last_q) && $stable(error_prev_q))
		else $error("held sample changed the controller history");
`endif

endmodule

`default_nettype wire

// File: bench/incremental_pid_pwm_core_tb.sv
`default_nettype none

// Self-checking bench for the incremental PID duty core. A queue-fed driver presents
// speed samples on the valid/ready input channel, and a clocked monitor checks each
// result transaction against a cycle-free model of the controller. The register
// settings change only between phases, after every outstanding result has drained.
module incremental_pid_pwm_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The run is ended if this many cycles pass with no transaction and no register write.
	localparam int QuietLimit = 1000;

	typedef struct packed {
		logic signed [ipp_pkg::SpeedW-1:0] setpoint;
		logic signed [ipp_pkg::SpeedW-1:0] feedback;
	} speed_sample_t;

	typedef struct packed {
		ipp_pkg::duty_t duty;
		ipp_pkg::step_t applied_step;
		logic           held;
	} duty_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                              sample_valid = 1'b0;
	logic                              sample_ready;
	logic signed [ipp_pkg::SpeedW-1:0] setpoint = '0;
	logic signed [ipp_pkg::SpeedW-1:0] feedback = '0;

	logic                              result_valid;
	logic                              result_ready = 1'b0;
	ipp_pkg::duty_t                    duty;
	ipp_pkg::step_t                    applied_step;
	logic                              held;

	logic                              cfg_we = 1'b0;
	ipp_pkg::cfg_reg_t                 cfg_index = ipp_pkg::REG_GAIN_NOW;
	logic [ipp_pkg::CfgW-1:0]          cfg_data = '0;

	incremental_pid_pwm_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.setpoint    (setpoint),
		.feedback    (feedback),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.duty        (duty),
		.applied_step(applied_step),
		.held        (held),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial forever #1 clk = ~clk;

	// Samples waiting to be driven, and results predicted but not yet seen.
	speed_sample_t pending_samples[$];
	duty_result_t  expected_duty_q[$];

	// Our own copy of the register file and of the controller state.
	logic [ipp_pkg::CfgW-1:0] reg_copy [8];
	ipp_pkg::err_t            err_last_q;
	ipp_pkg::err_t            err_prev_q;
	ipp_pkg::step_t           raw_step_q;
	ipp_pkg::duty_t           duty_level_q;

	// Bookkeeping shared by the driver, the monitor and the sequence.
	int   queued_count = 0;
	int   accepted_count = 0;
	int   result_count = 0;
	int   held_count = 0;
	int   setting_count = 0;
	int   fail_count = 0;
	int   quiet_cycles = 0;
	int   err_spread = 16;
	bit   bursts_on = 1'b1;
	bit   sample_took = 1'b0;
	int   feed_gap = 0;
	int   drain_gap = 0;

	// One controller step. A small error reuses the stored raw increment without any
	// clamping and leaves the error history alone. Otherwise a fresh increment is
	// formed from the three Q8.8 gains, truncated toward zero (SystemVerilog signed
	// division does exactly that), and then clamped: upper bound first, lower bound
	// second, so an inverted pair resolves to the lower bound. The duty clamps follow
	// the same order, which lets duty_min win when the pair is inverted.
	function automatic duty_result_t advance_controller(
			logic signed [ipp_pkg::SpeedW-1:0] sp,
			logic signed [ipp_pkg::SpeedW-1:0] fb);
		longint       err;
		longint       mag;
		longint       acc;
		longint       step;
		longint       total;
		longint       smax;
		longint       smin;
		duty_result_t res;

		err = longint'(sp) - longint'(fb);
		mag = (err < 0) ? -err : err;
		res.held = (mag < longint'(reg_copy[ipp_pkg::REG_DEADBAND]));

		if (res.held) begin
			step = longint'(raw_step_q);
		end else begin
			smax = longint'($signed(reg_copy[ipp_pkg::REG_STEP_MAX]));
			smin = longint'($signed(reg_copy[ipp_pkg::REG_STEP_MIN]));
			acc = longint'($signed(reg_copy[ipp_pkg::REG_GAIN_NOW])) * err
				+ longint'($signed(reg_copy[ipp_pkg::REG_GAIN_LAST])) * longint'(err_last_q)
				+ longint'($signed(reg_copy[ipp_pkg::REG_GAIN_PREV])) * longint'(err_prev_q);
			raw_step_q = ipp_pkg::step_t'(acc / 256);
			err_prev_q = err_last_q;
			err_last_q = ipp_pkg::err_t'(err);
			step = longint'(raw_step_q);
			if (step >= smax) begin
				step = smax;
			end
			if (step <= smin) begin
				step = smin;
			end
		end

		total = longint'(duty_level_q) + step;
		if (total > longint'(reg_copy[ipp_pkg::REG_DUTY_MAX])) begin
			total = longint'(reg_copy[ipp_pkg::REG_DUTY_MAX]);
		end
		if (total < longint'(reg_copy[ipp_pkg::REG_DUTY_MIN])) begin
			total = longint'(reg_copy[ipp_pkg::REG_DUTY_MIN]);
		end
		duty_level_q = ipp_pkg::duty_t'(total);

		res.duty = duty_level_q;
		res.applied_step = ipp_pkg::step_t'(step);
		return res;
	endfunction

	task automatic report_mismatch(string field, longint want, longint got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// Sender side. Inputs move on the falling edge only. A sample stays on the port
	// until the rising edge that completes its transaction, which the monitor flags in
	// sample_took. Random gaps are thrown in while bursts_on is set.
	always @(negedge clk) begin
		logic          next_valid;
		speed_sample_t item;

		next_valid = sample_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!sample_valid || sample_took) begin
			next_valid = 1'b0;
			if (feed_gap != 0) begin
				feed_gap--;
			end else if (pending_samples.size() != 0) begin
				if (bursts_on && $urandom_range(0, 4) == 0) begin
					feed_gap = $urandom_range(0, 2);
				end else begin
					item = pending_samples.pop_front();
					setpoint <= item.setpoint;
					feedback <= item.feedback;
					next_valid = 1'b1;
				end
			end
		end
		sample_valid <= next_valid;
	end

	// Receiver side: result_ready drops for short random stalls, again on the falling edge.
	always @(negedge clk) begin
		logic next_ready;

		if (!arst_n) begin
			next_ready = 1'b0;
		end else if (drain_gap != 0) begin
			drain_gap--;
			next_ready = 1'b0;
		end else if (bursts_on && $urandom_range(0, 4) == 0) begin
			drain_gap = $urandom_range(0, 2);
			next_ready = 1'b0;
		end else begin
			next_ready = 1'b1;
		end
		result_ready <= next_ready;
	end

	// Monitor. Everything here is sampled on the rising edge, after the inputs last moved
	// on the falling edge. Register writes are mirrored, each accepted sample feeds the
	// model, and each result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		duty_result_t want;
		bit           result_took;

		sample_took = (sample_valid === 1'b1) && (sample_ready === 1'b1);
		result_took = (result_valid === 1'b1) && (result_ready === 1'b1);

		if (cfg_we === 1'b1) begin
			reg_copy[cfg_index] = cfg_data;
		end

		if (sample_took) begin
			expected_duty_q.push_back(advance_controller(setpoint, feedback));
			accepted_count++;
		end

		if (result_took) begin
			result_count++;
			if (expected_duty_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none, got duty %0d step %0d held %0b",
					$time, duty, $signed(applied_step), held);
			end else begin
				want = expected_duty_q.pop_front();
				if (want.held) begin
					held_count++;
				end
				if (duty !== want.duty) begin
					report_mismatch("duty", longint'(want.duty), longint'(duty));
				end
				if (applied_step !== want.applied_step) begin
					report_mismatch("applied_step", longint'($signed(want.applied_step)),
						longint'($signed(applied_step)));
				end
				if (held !== want.held) begin
					report_mismatch("held", longint'(want.held), longint'(held));
				end
			end
		end

		if (sample_took || result_took || cfg_we === 1'b1) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		wait (quiet_cycles >= QuietLimit);
		$display("%0t: no transaction for %0d cycles", $time, QuietLimit);
		$display("incremental_pid_pwm_core_tb: FAIL");
		$finish;
	end

	task automatic queue_sample(logic signed [ipp_pkg::SpeedW-1:0] sp,
			logic signed [ipp_pkg::SpeedW-1:0] fb);
		speed_sample_t item;

		item.setpoint = sp;
		item.feedback = fb;
		pending_samples.push_back(item);
		queued_count++;
	endtask

	// Returns on a falling edge once every queued sample has been taken and every
	// predicted result has come back. The counters only move on rising edges.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (accepted_count != queued_count || expected_duty_q.size() != 0);
	endtask

	task automatic write_reg(ipp_pkg::cfg_reg_t idx, logic [ipp_pkg::CfgW-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	// Loads a full register setting while the core is idle. Every sample yields a
	// result, so an empty prediction queue means the pipeline is empty. Ends on a
	// rising edge so that samples queued afterwards never race the driver.
	task automatic apply_setting(logic [ipp_pkg::CfgW-1:0] gn, logic [ipp_pkg::CfgW-1:0] gl,
			logic [ipp_pkg::CfgW-1:0] gp, logic [ipp_pkg::CfgW-1:0] db,
			logic [ipp_pkg::CfgW-1:0] smax, logic [ipp_pkg::CfgW-1:0] smin,
			logic [ipp_pkg::CfgW-1:0] dmax, logic [ipp_pkg::CfgW-1:0] dmin);
		wait_drained();
		repeat (3) @(negedge clk);
		write_reg(ipp_pkg::REG_GAIN_NOW, gn);
		write_reg(ipp_pkg::REG_GAIN_LAST, gl);
		write_reg(ipp_pkg::REG_GAIN_PREV, gp);
		write_reg(ipp_pkg::REG_DEADBAND, db);
		write_reg(ipp_pkg::REG_STEP_MAX, smax);
		write_reg(ipp_pkg::REG_STEP_MIN, smin);
		write_reg(ipp_pkg::REG_DUTY_MAX, dmax);
		write_reg(ipp_pkg::REG_DUTY_MIN, dmin);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		setting_count++;
		err_spread = (db < 2000) ? 2 * int'(db) + 16 : 4000;
	endtask

	function automatic logic [ipp_pkg::CfgW-1:0] pick_gain();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ipp_pkg::CfgW'($urandom);
			default: return ipp_pkg::CfgW'(int'($urandom_range(0, 1024)) - 512);
		endcase
	endfunction

	function automatic logic [ipp_pkg::CfgW-1:0] pick_deadband();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ipp_pkg::CfgW'($urandom_range(1, 64));
			2: return ipp_pkg::CfgW'($urandom);
			default: return ipp_pkg::CfgW'($urandom_range(1, 600));
		endcase
	endfunction

	// A random register setting followed by a batch of samples. Most samples sit
	// near the feedback so that both held and fresh steps occur, with full-range
	// and extreme pairs mixed in.
	task automatic run_random_phase(int count);
		logic [ipp_pkg::CfgW-1:0] smax;
		logic [ipp_pkg::CfgW-1:0] smin;
		logic [ipp_pkg::CfgW-1:0] dmax;
		logic [ipp_pkg::CfgW-1:0] dmin;
		int                       sp;
		int                       fb;

		if ($urandom_range(0, 3) != 0) begin
			smax = ipp_pkg::CfgW'($urandom_range(0, 32767));
			smin = ipp_pkg::CfgW'(-int'($urandom_range(0, 32768)));
		end else begin
			smax = ipp_pkg::CfgW'($urandom);
			smin = ipp_pkg::CfgW'($urandom);
		end
		if ($urandom_range(0, 3) != 0) begin
			dmin = ipp_pkg::CfgW'($urandom_range(0, 30000));
			dmax = ipp_pkg::CfgW'($urandom_range(int'(dmin), 65535));
		end else begin
			dmin = ipp_pkg::CfgW'($urandom);
			dmax = ipp_pkg::CfgW'($urandom);
		end
		apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_deadband(),
			smax, smin, dmax, dmin);

		repeat (count) begin
			sp = int'($urandom_range(0, 65535)) - 32768;
			case ($urandom_range(0, 9))
				0, 1: fb = int'($urandom_range(0, 65535)) - 32768;
				2: begin
					sp = $urandom_range(0, 1) ? 32767 : -32768;
					fb = $urandom_range(0, 1) ? 32767 : -32768;
				end
				default: fb = sp + int'($urandom_range(0, 2 * err_spread)) - err_spread;
			endcase
			queue_sample(ipp_pkg::SpeedW'(sp), ipp_pkg::SpeedW'(fb));
		end
	endtask

	initial begin
		reg_copy[ipp_pkg::REG_GAIN_NOW]  = '0;
		reg_copy[ipp_pkg::REG_GAIN_LAST] = '0;
		reg_copy[ipp_pkg::REG_GAIN_PREV] = '0;
		reg_copy[ipp_pkg::REG_DEADBAND]  = '0;
		reg_copy[ipp_pkg::REG_STEP_MAX]  = ipp_pkg::StepMaxRst;
		reg_copy[ipp_pkg::REG_STEP_MIN]  = ipp_pkg::StepMinRst;
		reg_copy[ipp_pkg::REG_DUTY_MAX]  = ipp_pkg::DutyMaxRst;
		reg_copy[ipp_pkg::REG_DUTY_MIN]  = ipp_pkg::DutyMinRst;
		err_last_q = '0;
		err_prev_q = '0;
		raw_step_q = '0;
		duty_level_q = '0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults straight out of reset: all gains are zero, so nothing moves.
		queue_sample(16'sh7FFF, -16'sh8000);
		queue_sample(-16'sh8000, 16'sh7FFF);
		queue_sample('0, '0);

		// Moderate gains with a deadband of ten. The first sample is held before any
		// fresh step exists, so zero is applied and the duty rises to its floor. A held
		// sample after a huge fresh step replays the raw step without the step clamp.
		// An error of exactly the deadband is not held.
		apply_setting(16'h0180, 16'hFF80, 16'h0040, 16'd10, 16'd2000, 16'hF830,
			16'd60000, 16'd100);
		queue_sample('0, '0);
		queue_sample(16'sd4, -16'sd5);
		queue_sample(16'sd1000, '0);
		queue_sample(16'sh7FFF, -16'sh8000);
		queue_sample(-16'sd5, 16'sd4);
		queue_sample(-16'sh8000, 16'sh7FFF);
		queue_sample(16'sd10, '0);
		queue_sample(-16'sd9, '0);
		queue_sample(-16'sh8000, -16'sh8000);
		queue_sample(-16'sd10, '0);

		// Extreme gains, zero deadband (nothing is ever held), and both clamp pairs
		// inverted so that the lower bounds win.
		apply_setting(16'h7FFF, 16'h8000, 16'h8000, '0, 16'hFF9C, 16'd100,
			16'd1000, 16'd2000);
		queue_sample('0, '0);
		queue_sample(16'sh7FFF, -16'sh8000);
		queue_sample(-16'sh8000, 16'sh7FFF);
		queue_sample(-16'sd1, '0);
		queue_sample(16'sd1, '0);

		// Widest deadband: only the largest error magnitude gets a fresh step.
		apply_setting(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000,
			16'hFFFF, '0);
		queue_sample(16'sh7FFF, -16'sh8000);
		queue_sample(-16'sh8000, 16'sh7FFF);
		queue_sample(16'sd100, -16'sd200);
		queue_sample(-16'sh8000, 16'sh7FFF);

		// Random settings and samples. The last phase runs with no stalls at all.
		repeat (7) begin
			run_random_phase(115);
		end
		wait_drained();
		bursts_on = 1'b0;
		run_random_phase(125);

		wait_drained();
		repeat (4) @(negedge clk);
		if (expected_duty_q.size() != 0) begin
			$display("%0t: %0d predicted results never arrived", $time, expected_duty_q.size());
			fail_count += expected_duty_q.size();
		end

		$display("Checked %0d results from %0d samples (%0d in the deadband) over %0d settings,",
			result_count, accepted_count, held_count, setting_count + 1);
		$display("with step and duty clamps, inverted clamp pairs and random stalls on both sides.");
		if (fail_count == 0) begin
			$display("incremental_pid_pwm_core_tb: PASS");
		end else begin
			$display("incremental_pid_pwm_core_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
